FILE: rtl/core/slri_pkg.sv
// package: shared constants and command/status types for the shuffled lcg core
`default_nettype none
package slri_pkg;
   localparam logic [30:0] LCG_MOD = 31'h7FFF_FFFF;
   localparam logic [14:0] LCG_MUL = 15'd16807;
   localparam logic [31:0] RAW_MAX = 32'h7FFF_FFFF;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load_req;    // capture request fields
      logic seed_wr;     // capture new seed
      logic warm_init;   // load warm-up start value
      logic lcg_step;    // one generator step
      logic tbl_write;   // write next lcg value at warm-up index
      logic warm_done;   // take table entry zero as last output
      logic draw_rd;     // read shuffle entry (index from last output)
      logic draw_swap;   // swap in new value, update last output
      logic mod_start;   // start remainder unit
      logic mod_step;    // one remainder step
      logic finish;      // form result
   } cmd_type;

   typedef struct packed {
      logic need_warm;
      logic degenerate;
      logic raw_mode;
      logic reject;
   } status_type;
endpackage
`default_nettype wire

FILE: rtl/core/shuffled_lcg_random_int_core.sv
// top level: minimal-standard generator with shuffle table and ranged output
// Usage: csr_valid/csr_ready write the seed (only while idle); it re-arms warm-up.
// req_* carries one transaction: action 0 returns the raw shuffled number,
// action 1 an unbiased integer in [range_low, range_high] (range_low if the
// span is degenerate). rsp_* returns value.
// A raw request runs a generator step and a shuffle-table swap; a degenerate
// ranged one skips the draw. A ranged draw adds the bit-serial remainder
// unit, and each rejection adds another fresh draw and remainder. The first
// draw after reset or a seed write first runs a warm-up that fills the
// shuffle table, one generator step per cycle.
// One request is processed at a time; the result sits in an output register,
// and a new request is taken only after that result has been accepted.
// Reset clears the controller and makes the generator need warm-up; the seed
// state resets to zero. If the receiver stalls, value and rsp_valid hold and
// req_ready stays low.
`default_nettype none
module shuffled_lcg_random_int_core #(
   parameter int TABLE_DEPTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [31:0] csr_seed,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic        req_action,
   input  wire logic [31:0] req_range_low,
   input  wire logic [31:0] req_range_high,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [31:0] rsp_value
);
   import slri_pkg::*;
   cmd_type    cmd;
   status_type stat;
   logic [$clog2(TABLE_DEPTH)-1:0] warm_idx;

   slri_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .csr_valid, .csr_ready,
      .rsp_valid, .rsp_ready, .stat, .cmd, .warm_idx
   );
   slri_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
      .clock, .reset, .csr_seed, .req_action, .req_range_low, .req_range_high,
      .cmd, .warm_idx, .stat, .result(rsp_value)
   );
endmodule
`default_nettype wire

FILE: rtl/core/slri_datapath.sv
// datapath: generator, shuffle table, rejection test and remainder unit
`default_nettype none
module slri_datapath #(
   parameter int TABLE_DEPTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [31:0]        csr_seed,
   input  wire logic               req_action,
   input  wire logic [31:0]        req_range_low,
   input  wire logic [31:0]        req_range_high,
   input  wire slri_pkg::cmd_type  cmd,
   input  wire logic [$clog2(TABLE_DEPTH)-1:0] warm_idx,
   output      slri_pkg::status_type stat,
   output      logic [31:0]        result
);
   import slri_pkg::*;
   localparam int IW = $clog2(TABLE_DEPTH);
   localparam logic [31:0] NDIV = 32'(1 + (2147483646 / TABLE_DEPTH));

   logic [31:0] lcg_ff, lcg_in;
   logic        armed_ff;     // warm-up done since the last seed write or reset
   logic [30:0] last_ff;
   logic [30:0] mem [TABLE_DEPTH];
   logic [30:0] rd_ff;
   logic        act_ff;
   logic [31:0] lo_ff, x_ff;
   logic [31:0] rem_ff;
   logic [32:0] rem2;
   logic [31:0] n_ff;
   logic [4:0]  bit_ff;

   // generator step on 31-bit value; full mult fits 46 bits, fold mod 2^31-1
   logic [31:0] cur;
   logic [45:0] prod;
   logic [31:0] fold;
   logic [31:0] lcg_nxt;
   always_comb begin
      cur  = lcg_ff;
      prod = 46'(cur) * 46'(LCG_MUL);
      fold = 32'(prod[30:0]) + 32'(prod[45:31]);
      lcg_nxt = (fold >= 32'(LCG_MOD)) ? fold - 32'(LCG_MOD) : fold;
   end

   // warm-up start: -lcg (as signed), or 1
   logic [31:0] neg;
   logic [31:0] start;
   logic [32:0] mag;
   always_comb begin
      neg = 32'd0 - lcg_ff;
      mag = lcg_ff[31] ? 33'(neg) : 33'd0;
      if (lcg_ff == 32'h8000_0000) mag = 33'h1_0000_0000 >> 1;
      start = (mag == 33'd0) ? 32'd1 : mag[31:0];
   end

   // index: last / NDIV, found by comparing against the slot boundaries
   logic [IW-1:0] idx;
   always_comb begin
      idx = '0;
      for (int j = 1; j < TABLE_DEPTH; j++) begin
         if ({1'b0, last_ff} >= 32'(j) * NDIV) idx = IW'(j);
      end
   end

   // span
   logic [31:0] span;
   assign span = req_range_high - req_range_low + 32'd1;

   always_comb begin
      lcg_in = lcg_ff;
      if (cmd.seed_wr) lcg_in = csr_seed[31] ? csr_seed : 32'd0 - csr_seed;
      else if (cmd.warm_init) lcg_in = start;
      else if (cmd.lcg_step) lcg_in = lcg_nxt;
   end

   assign rem2 = {rem_ff, n_ff[bit_ff]};

   always_ff @(posedge clock) begin
      if (reset) begin
         lcg_ff   <= '0;
         armed_ff <= 1'b0;
      end else begin
         lcg_ff <= lcg_in;
         if (cmd.seed_wr) armed_ff <= 1'b0;
         else if (cmd.warm_done) armed_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tbl_write) mem[warm_idx] <= lcg_nxt[30:0];
      if (cmd.warm_done) last_ff <= mem[0];
      if (cmd.draw_rd) rd_ff <= mem[idx];
      if (cmd.draw_swap) begin
         mem[idx] <= lcg_ff[30:0];
         last_ff  <= rd_ff;
      end
      if (cmd.load_req) begin
         act_ff   <= req_action;
         lo_ff    <= req_range_low;
         x_ff     <= span;
      end
      if (cmd.mod_start) begin
         n_ff   <= {1'b0, rd_ff};
         rem_ff <= 32'd0;
         bit_ff <= 5'd31;
      end
      if (cmd.mod_step) begin
         rem_ff <= (rem2 >= 33'(x_ff)) ? 32'(rem2 - 33'(x_ff)) : rem2[31:0];
         bit_ff <= bit_ff - 5'd1;
      end
      if (cmd.finish) result <= act_ff ? ((x_ff <= 32'd1 || x_ff - 32'd1 > RAW_MAX) ?
         lo_ff : lo_ff + rem_ff) : {1'b0, last_ff};
   end

   // n is rejected iff n > RAW_MAX - (2^31 mod x), which is the same as
   // n - n%x + x > 2^31, so the remainder of n is enough for the test
   logic [32:0] top;
   assign top = 33'(n_ff) - 33'(rem_ff) + 33'(x_ff);
   assign stat.reject     = top > 33'h0_8000_0000;
   assign stat.need_warm  = !lcg_ff[31] && lcg_ff == 32'd0 || lcg_ff[31] || !armed_ff;
   assign stat.degenerate = x_ff <= 32'd1 || x_ff - 32'd1 > RAW_MAX;
   assign stat.raw_mode   = !act_ff;
endmodule
`default_nettype wire

FILE: rtl/core/slri_ctrl.sv
// controller: sequences warm-up, draw, remainder and handshakes
`default_nettype none
module slri_ctrl #(
   parameter int TABLE_DEPTH = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output      logic req_ready,
   input  wire logic csr_valid,
   output      logic csr_ready,
   output      logic rsp_valid,
   input  wire logic rsp_ready,
   input  wire slri_pkg::status_type stat,
   output      slri_pkg::cmd_type cmd,
   output      logic [$clog2(TABLE_DEPTH)-1:0] warm_idx
);
   import slri_pkg::*;
   localparam int IW = $clog2(TABLE_DEPTH);
   localparam logic [3:0] S_IDLE = 4'd0, S_CHK = 4'd1, S_WINIT = 4'd2, S_WARM = 4'd3,
      S_WDONE = 4'd4, S_STEP = 4'd5, S_RD = 4'd6, S_SWAP = 4'd7, S_MODS = 4'd8,
      S_MOD = 4'd9, S_TEST = 4'd10, S_FIN = 4'd11, S_OUT = 4'd12;
   logic [3:0] state_ff, state_in;
   logic [6:0] cnt_ff, cnt_in;
   logic       rv_ff, rv_in;

   assign req_ready = state_ff == S_IDLE && !csr_valid && !rv_ff;
   assign csr_ready = state_ff == S_IDLE;
   assign rsp_valid = rv_ff;
   assign warm_idx  = IW'(cnt_ff);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rv_in    = rv_ff && !rsp_ready;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (csr_valid) cmd.seed_wr = 1'b1;
            else if (req_valid && !rv_ff) begin
               cmd.load_req = 1'b1;
               state_in = S_CHK;
            end
         end
         S_CHK: state_in = (!stat.raw_mode && stat.degenerate) ? S_FIN :
            (stat.need_warm ? S_WINIT : S_STEP);
         S_WINIT: begin
            cmd.warm_init = 1'b1;
            cnt_in = 7'(TABLE_DEPTH + 7);
            state_in = S_WARM;
         end
         S_WARM: begin
            cmd.lcg_step = 1'b1;
            cmd.tbl_write = cnt_ff < 7'(TABLE_DEPTH);
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd0) state_in = S_WDONE;
         end
         S_WDONE: begin
            cmd.warm_done = 1'b1;
            state_in = S_STEP;
         end
         S_STEP: begin
            cmd.lcg_step = 1'b1;
            state_in = S_RD;
         end
         S_RD: begin
            cmd.draw_rd = 1'b1;
            state_in = S_SWAP;
         end
         S_SWAP: begin
            cmd.draw_swap = 1'b1;
            state_in = stat.raw_mode ? S_FIN : S_MODS;
         end
         S_MODS: begin
            cmd.mod_start = 1'b1;
            cnt_in = 7'd31;
            state_in = S_MOD;
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd0) state_in = S_TEST;
         end
         S_TEST: state_in = stat.reject ? S_STEP : S_FIN;
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rv_ff) begin
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rv_ff    <= rv_in;
      end
   end
endmodule
`default_nettype wire
